// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define PVMA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication out of reset
`define PVMA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/pvma_pkg.sv =====
// ---------------------------------------------------------------------------
// pvma_pkg
// Shared constants and types of the pose velocity moving-average block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvma_pkg;

   localparam int WINDOW_DEFAULT   = 8;
   localparam int DIV_W            = 64;
   localparam int CNT_W            = 7;
   localparam int VEL_ITERS        = 62;
   localparam int MIN_W            = 34;
   localparam logic [MIN_W-1:0] MIN_INTERVAL_RESET = 34'd100000000;
   localparam logic [29:0]      NS_PER_S           = 30'd1000000000;

   // divider control from the sequencer
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] iters;
   } div_ctl_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ===== src/pose_velocity_moving_average.sv =====
// ---------------------------------------------------------------------------
// pose_velocity_moving_average
// Finite-difference pose velocity with a moving-average window.
// ---------------------------------------------------------------------------
// Takes one pose sample at a time. A zero stamp is answered with ok clear and
// a zeroed payload. Any other sample that is stored has its velocities divided
// (when an earlier sample with another stamp is held), is pushed into the
// window and then has both window means divided; one that comes too early
// only has the window means divided. The single bit-per-cycle divider is used
// in turn for both velocity quotients and both window means. The result
// register lets the next sample be taken while a result waits; a second
// finished result holds the block until the first one has left.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pose_velocity_moving_average #(
   parameter int WINDOW = pvma_pkg::WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // config: min_interval_ns
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pvma_pkg::MIN_W-1:0] csr_data,
   // tdata: stamp_ns[63:0], pos_x[95:64], pos_y[127:96]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [127:0]               req_tdata,
   // tdata: out_stamp_ns[63:0], vel_x[95:64], vel_y[127:96],
   //        out_x[159:128], out_y[191:160]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [191:0]               rsp_tdata,
   // tuser: ok[0]
   output logic [0:0]                 rsp_tuser
);
   import pvma_pkg::*;

   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = 33 + $clog2(WINDOW);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_CHECK  = 10'b0000000010,
      ST_MUL    = 10'b0000000100,
      ST_VSTART = 10'b0000001000,
      ST_VWAIT  = 10'b0000010000,
      ST_PUSH   = 10'b0000100000,
      ST_MSTART = 10'b0001000000,
      ST_MWAIT  = 10'b0010000000,
      ST_DONE   = 10'b0100000000,
      ST_ZERO   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [MIN_W-1:0] min_ff;

   // stored state
   logic [63:0]       last_stamp_ff, last_stamp_in;
   logic [31:0]       last_px_ff, last_px_in;
   logic [31:0]       last_py_ff, last_py_in;
   logic              have_ff, have_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]  sum_y_ff, sum_y_in;

   // per-item working registers
   logic [63:0] stamp_ff, stamp_in;
   logic [31:0] px_ff, px_in;
   logic [31:0] py_ff, py_in;
   logic        take_ff, take_in;
   logic [63:0] gap_ff, gap_in;
   logic [32:0] dx_ff, dx_in;
   logic [32:0] dy_ff, dy_in;
   logic        axis_ff, axis_in;
   logic [61:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   logic [31:0] vx_ff, vx_in;
   logic [31:0] vy_ff, vy_in;
   logic [31:0] mx_ff, mx_in;
   logic [31:0] my_ff, my_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [191:0] rsp_data_ff, rsp_data_in;
   logic         rsp_ok_ff, rsp_ok_in;

   // divider and ring hookup
   div_ctl_type      div_ctl;
   div_sts_type      div_sts;
   logic [DIV_W-1:0] div_num, div_den, div_quot;
   logic             ring_wr, ring_rd;
   logic [63:0]      ring_rdata;

   // helpers
   logic [64:0]      limit;
   logic             early;
   logic [32:0]      d_sel, d_mag;
   logic [62:0]      prod_full;
   logic [SUM_W-1:0] sum_sel, sum_mag;
   logic [DIV_W-1:0] q_sat;
   logic [31:0]      q_lo;
   logic [SUM_W-1:0] old_x, old_y;
   logic             full;
   logic             rsp_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (fill_ff == FILL_W'(WINDOW));

   // datapath helpers
   always_comb begin
      limit     = {1'b0, last_stamp_ff} + {{(65-MIN_W){1'b0}}, min_ff};
      early     = have_ff && ({1'b0, stamp_ff} < limit);
      d_sel     = axis_ff ? dy_ff : dx_ff;
      d_mag     = d_sel[32] ? (33'd0 - d_sel) : d_sel;
      prod_full = 63'(d_mag) * 63'(NS_PER_S);
      sum_sel   = axis_ff ? sum_y_ff : sum_x_ff;
      sum_mag   = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
      old_x     = full ? {{(SUM_W-32){ring_rdata[31]}}, ring_rdata[31:0]} : '0;
      old_y     = full ? {{(SUM_W-32){ring_rdata[63]}}, ring_rdata[63:32]} : '0;
      // velocity saturation
      q_sat = div_quot;
      if (neg_ff && (div_quot > 64'h0000_0000_8000_0000)) begin
         q_sat = 64'h0000_0000_8000_0000;
      end else if (!neg_ff && (div_quot > 64'h0000_0000_7FFF_FFFF)) begin
         q_sat = 64'h0000_0000_7FFF_FFFF;
      end
      q_lo = neg_ff ? (32'd0 - q_sat[31:0]) : q_sat[31:0];
   end

   // divider operand select
   always_comb begin
      div_ctl.start = 1'b0;
      div_ctl.iters = CNT_W'(VEL_ITERS);
      div_num       = {prod_ff, 2'b00};
      div_den       = gap_ff;
      if (state_ff == ST_VSTART) begin
         div_ctl.start = 1'b1;
      end else if (state_ff == ST_MSTART) begin
         div_ctl.start = (fill_ff != '0);
         div_ctl.iters = CNT_W'(SUM_W);
         div_num       = {sum_mag, {(DIV_W-SUM_W){1'b0}}};
         div_den       = {{(DIV_W-FILL_W){1'b0}}, fill_ff};
      end
   end

   assign ring_rd = (state_ff == ST_CHECK);
   assign ring_wr = (state_ff == ST_PUSH);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      last_stamp_in = last_stamp_ff;
      last_px_in    = last_px_ff;
      last_py_in    = last_py_ff;
      have_in       = have_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      stamp_in      = stamp_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      take_in       = take_ff;
      gap_in        = gap_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      axis_in       = axis_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_ok_in     = rsp_ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               stamp_in = req_tdata[63:0];
               px_in    = req_tdata[95:64];
               py_in    = req_tdata[127:96];
               state_in = (req_tdata[63:0] == 64'd0) ? ST_ZERO : ST_CHECK;
            end
         end
         ST_CHECK: begin
            take_in  = !early;
            gap_in   = stamp_ff - last_stamp_ff;
            dx_in    = {px_ff[31], px_ff} - {last_px_ff[31], last_px_ff};
            dy_in    = {py_ff[31], py_ff} - {last_py_ff[31], last_py_ff};
            axis_in  = 1'b0;
            vx_in    = '0;
            vy_in    = '0;
            if (early) begin
               state_in = ST_MSTART;
            end else if (!have_ff || (stamp_ff == last_stamp_ff)) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full[61:0];
            neg_in   = d_sel[32];
            state_in = ST_VSTART;
         end
         ST_VSTART: begin
            state_in = ST_VWAIT;
         end
         ST_VWAIT: begin
            if (div_sts.done) begin
               if (axis_ff) begin
                  vy_in    = q_lo;
                  axis_in  = 1'b0;
                  state_in = ST_PUSH;
               end else begin
                  vx_in    = q_lo;
                  axis_in  = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_PUSH: begin
            sum_x_in = sum_x_ff - old_x + {{(SUM_W-32){vx_ff[31]}}, vx_ff};
            sum_y_in = sum_y_ff - old_y + {{(SUM_W-32){vy_ff[31]}}, vy_ff};
            head_in  = (head_ff == IDX_W'(WINDOW - 1)) ? '0 : head_ff + IDX_W'(1);
            if (!full) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            last_stamp_in = stamp_ff;
            last_px_in    = px_ff;
            last_py_in    = py_ff;
            have_in       = 1'b1;
            state_in      = ST_MSTART;
         end
         ST_MSTART: begin
            neg_in = sum_sel[SUM_W-1];
            if (fill_ff == '0) begin
               mx_in    = '0;
               my_in    = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            if (div_sts.done) begin
               if (axis_ff) begin
                  my_in    = neg_ff ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
                  axis_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  mx_in    = neg_ff ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
                  axis_in  = 1'b1;
                  state_in = ST_MSTART;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_data_in  = {py_ff, px_ff, my_ff, mx_ff, stamp_ff};
               state_in     = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_ff        <= MIN_INTERVAL_RESET;
         last_stamp_ff <= '0;
         last_px_ff    <= '0;
         last_py_ff    <= '0;
         have_ff       <= 1'b0;
         head_ff       <= '0;
         fill_ff       <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         axis_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_valid) begin
            min_ff <= csr_data;
         end
         last_stamp_ff <= last_stamp_in;
         last_px_ff    <= last_px_in;
         last_py_ff    <= last_py_in;
         have_ff       <= have_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         axis_ff       <= axis_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      stamp_ff    <= stamp_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      take_ff     <= take_in;
      gap_ff      <= gap_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   pvma_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   pvma_ring #(
      .WINDOW (WINDOW),
      .IDX_W  (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (head_ff),
      .wr_data ({vy_ff, vx_ff}),
      .rd_en   (ring_rd),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_ok_ff;

   // checks
   `PVMA_ASSERT(a_fill_bound, clock, reset, fill_ff <= FILL_W'(WINDOW), "fill count past window")
   `PVMA_ASSERT(a_head_bound, clock, reset, head_ff <= IDX_W'(WINDOW - 1), "ring head out of range")
   `PVMA_ASSERT_IMPL(a_div_idle, clock, reset, div_ctl.start, !div_sts.busy, "divider restarted while busy")
   `PVMA_ASSERT_IMPL(a_push_taken, clock, reset, state_ff == ST_PUSH, take_ff, "push of a rejected sample")

endmodule

// ===== src/pvma_div.sv =====
// ---------------------------------------------------------------------------
// pvma_div
// Restoring unsigned divider, one quotient bit per cycle. The numerator is
// left aligned by the caller; iters bits are taken from its top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvma_div (
   input  logic                       clock,
   input  logic                       reset,
   input  pvma_pkg::div_ctl_type      ctl,
   input  logic [pvma_pkg::DIV_W-1:0] num,
   input  logic [pvma_pkg::DIV_W-1:0] den,
   output pvma_pkg::div_sts_type      sts,
   output logic [pvma_pkg::DIV_W-1:0] quot
);
   import pvma_pkg::*;

   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_sh;
   logic [DIV_W+1:0] diff;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff[DIV_W-1:0], num_ff[DIV_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = '0;
         num_in  = num;
         den_in  = den;
         cnt_in  = ctl.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W+1]) begin
            rem_in = diff[DIV_W:0];
         end else begin
            rem_in = rem_sh;
         end
         num_in = {num_ff[DIV_W-2:0], ~diff[DIV_W+1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = num_ff;

endmodule

// ===== src/pvma_ring.sv =====
// ---------------------------------------------------------------------------
// pvma_ring
// Velocity window memory: one write port, one registered read port.
// Each word holds {vel_y, vel_x}.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvma_ring #(
   parameter int WINDOW = pvma_pkg::WINDOW_DEFAULT,
   parameter int IDX_W  = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [63:0]      wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [63:0]      rd_data
);
   logic [63:0] mem [WINDOW];
   logic [63:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
